@@ sv/mma_pkg.sv @@
// ---------------------------------------------------------------------------
// mma_pkg
// Shared types, constants and helpers of the matrix multiply-accumulate core.
// ---------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

    localparam int VAL_W     = 32;   // Q16.16 element word
    localparam int FRAC_W    = 16;   // fraction bits of an element
    localparam int IDX_W     = 6;    // flat element index
    localparam int DIM_W     = 4;    // dimension register width
    localparam int CFG_IDX_W = 2;    // configuration register index

    localparam int DEFAULT_MAX_DIM     = 8;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic [DIM_W-1:0] RESET_DIM = 4'd8;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_LOAD_C = 2'd2,
        CMD_RUN    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [IDX_W-1:0]         idx;
        logic signed [VAL_W-1:0]  value;
    } mma_item_t;

    // Effective (clamped) matrix dimensions
    typedef struct packed {
        logic [DIM_W-1:0] m;
        logic [DIM_W-1:0] n;
        logic [DIM_W-1:0] k;
    } mma_dims_t;

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                                 input int max_dim);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(max_dim);
        if (r == '0) begin
            return DIM_W'(1);
        end
        if (r > lim) begin
            return lim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/matrix_multiply_accumulate_core.sv @@
// Loads: one item per cycle unless stalled; queued, then written by the idle engine.
// Run: M*N*K product terms on the single multiply-accumulate pipeline, one
//   per cycle unless a result stall holds it; each result passes the read,
//   product, accumulate and output registers in turn.
// After a run the pipeline drains before the next item executes.
// Reset: dimensions return to 8, the queue empties, the C store reads as zero;
//   A and B hold no defined contents until written.
// ---------------------------------------------------------------------------
// matrix_multiply_accumulate_core
// C = C + A*B in Q16.16 with a command queue between input and engine.
// ---------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_accumulate_core import mma_pkg::*;
#(
    parameter int MAX_DIM     = DEFAULT_MAX_DIM,
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [DIM_W-1:0]         cfg_data,
    input  wire logic                     cmd_valid,
    output logic                          cmd_stall,
    input  wire logic [1:0]               command,
    input  wire logic [IDX_W-1:0]         elem_index,
    input  wire logic signed [VAL_W-1:0]  elem_value,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic signed [VAL_W-1:0]       result_value,
    output logic [IDX_W-1:0]              result_index,
    output logic                          is_last
);

    logic [DIM_W-1:0] rows_m_reg, cols_n_reg, inner_k_reg;
    mma_dims_t        dims;
    logic             q_full, q_push, q_pop, q_valid;
    mma_item_t        push_item, q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= RESET_DIM;
            cols_n_reg  <= RESET_DIM;
            inner_k_reg <= RESET_DIM;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_ROWS_M:  rows_m_reg  <= cfg_data;
                REG_COLS_N:  cols_n_reg  <= cfg_data;
                REG_INNER_K: inner_k_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign dims.m = eff_dim(rows_m_reg, MAX_DIM);
    assign dims.n = eff_dim(cols_n_reg, MAX_DIM);
    assign dims.k = eff_dim(inner_k_reg, MAX_DIM);

    mma_front u_front
    (
        .dims       (dims),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .command    (command),
        .elem_index (elem_index),
        .elem_value (elem_value),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    mma_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    mma_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .dims         (dims),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_value (result_value),
        .result_index (result_index),
        .is_last      (is_last)
    );

endmodule

`default_nettype wire

@@ sv/mma_front.sv @@
// ---------------------------------------------------------------------------
// mma_front
// Input side: takes items, drops loads that fall outside the configured
// matrix, and pushes the rest into the command queue.
// ---------------------------------------------------------------------------
`default_nettype none

module mma_front import mma_pkg::*;
(
    input  wire mma_dims_t                dims,
    input  wire logic                     cmd_valid,
    output logic                          cmd_stall,
    input  wire logic [1:0]               command,
    input  wire logic [IDX_W-1:0]         elem_index,
    input  wire logic signed [VAL_W-1:0]  elem_value,
    input  wire logic                     q_full,
    output logic                          q_push,
    output mma_item_t                     q_item
);

    localparam int LW = 2 * DIM_W;

    logic [LW-1:0] limit;
    logic          keep;
    cmd_t          cmd;

    assign cmd = cmd_t'(command);

    always_comb
    begin
        limit = '0;
        keep  = 1'b1;
        unique case (cmd)
            CMD_LOAD_A:
            begin
                limit = LW'(dims.m) * LW'(dims.k);
                keep  = LW'(elem_index) < limit;
            end
            CMD_LOAD_B:
            begin
                limit = LW'(dims.k) * LW'(dims.n);
                keep  = LW'(elem_index) < limit;
            end
            CMD_LOAD_C:
            begin
                limit = LW'(dims.m) * LW'(dims.n);
                keep  = LW'(elem_index) < limit;
            end
            CMD_RUN:
            begin
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign cmd_stall    = q_full;
    assign q_push       = cmd_valid && !q_full && keep;
    assign q_item.cmd   = cmd;
    assign q_item.idx   = elem_index;
    assign q_item.value = elem_value;

endmodule

`default_nettype wire

@@ sv/mma_queue.sv @@
// ---------------------------------------------------------------------------
// mma_queue
// Short FIFO of commands between the input side and the execution engine.
// ---------------------------------------------------------------------------
`default_nettype none

module mma_queue import mma_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire mma_item_t  push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            q_valid,
    output mma_item_t       q_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    mma_item_t       mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg,  count_next;
    logic            do_pop;

    assign full    = count_reg == NW'(DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ sv/mma_back.sv @@
// ---------------------------------------------------------------------------
// mma_back
// Execution engine: element stores, index sequencer and one pipelined
// multiply-accumulate unit (read, multiply, accumulate, round and saturate).
// ---------------------------------------------------------------------------
`default_nettype none

module mma_back import mma_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mma_dims_t                dims,
    input  wire logic                     q_valid,
    input  wire mma_item_t                q_item,
    output logic                          q_pop,
    input  wire logic                     result_stall,
    output logic                          result_valid,
    output logic signed [VAL_W-1:0]       result_value,
    output logic [IDX_W-1:0]              result_index,
    output logic                          is_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int LW    = 2 * DIM_W;
    localparam int PRD_W = 2 * VAL_W;
    localparam int ACC_W = PRD_W + CW + 1;
    localparam int RND_W = ACC_W - FRAC_W;
    localparam int TOT_W = RND_W + 1;

    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (FRAC_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } back_state_t;

    typedef struct packed {
        logic          valid;
        logic          first;
        logic          last;
        logic          run_last;
        logic [AW-1:0] ci;
    } mma_tag_t;

    back_state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] t_reg, t_next;

    logic signed [VAL_W-1:0] store_a [DEPTH];
    logic signed [VAL_W-1:0] store_b [DEPTH];
    logic signed [VAL_W-1:0] store_c [DEPTH];
    logic [DEPTH-1:0]        c_valid_reg;

    logic          adv;
    logic          issue;
    logic          i_last, j_last, t_last;
    logic [LW-1:0] a_lin, b_lin, c_lin;
    logic [AW-1:0] a_addr, b_addr, c_addr, ld_addr;
    mma_tag_t      issue_tag;
    logic          pipe_empty;
    logic          ld_a, ld_b, ld_c, start_run;

    mma_tag_t                s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic signed [VAL_W-1:0] a_rd_reg, b_rd_reg, c_rd_reg;
    logic                    c_hit_reg;
    logic signed [VAL_W-1:0] s2_c_reg, s3_c_reg;
    logic signed [PRD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic signed [RND_W-1:0] rnd;
    logic signed [TOT_W-1:0] total;
    logic signed [VAL_W-1:0] sat_value;
    logic                    finish;

    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [IDX_W-1:0]        out_index_reg;
    logic                    out_last_reg;

    // The whole compute pipeline holds while a result waits on a stall.
    assign adv = !out_valid_reg || !result_stall;

    assign pipe_empty = !s1_tag_reg.valid && !s2_tag_reg.valid && !s3_tag_reg.valid;
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign ld_a       = q_pop && (q_item.cmd == CMD_LOAD_A);
    assign ld_b       = q_pop && (q_item.cmd == CMD_LOAD_B);
    assign ld_c       = q_pop && (q_item.cmd == CMD_LOAD_C);
    assign start_run  = q_pop && (q_item.cmd == CMD_RUN);
    assign ld_addr    = AW'(q_item.idx);

    assign issue  = (state_reg == ST_RUN);
    assign i_last = DIM_W'(i_reg) == dims.m - DIM_W'(1);
    assign j_last = DIM_W'(j_reg) == dims.n - DIM_W'(1);
    assign t_last = DIM_W'(t_reg) == dims.k - DIM_W'(1);

    assign a_lin  = LW'(i_reg) * LW'(dims.k) + LW'(t_reg);
    assign b_lin  = LW'(t_reg) * LW'(dims.n) + LW'(j_reg);
    assign c_lin  = LW'(i_reg) * LW'(dims.n) + LW'(j_reg);
    assign a_addr = a_lin[AW-1:0];
    assign b_addr = b_lin[AW-1:0];
    assign c_addr = c_lin[AW-1:0];

    assign issue_tag.valid    = issue;
    assign issue_tag.first    = t_reg == '0;
    assign issue_tag.last     = t_last;
    assign issue_tag.run_last = i_last && j_last;
    assign issue_tag.ci       = c_addr;

    // Sequencer: one product term per cycle while the pipeline advances, t innermost, then j, then i.
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_run)
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    t_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    if (!t_last)
                    begin
                        t_next = t_reg + 1'b1;
                    end
                    else
                    begin
                        t_next = '0;
                        if (!j_last)
                        begin
                            j_next = j_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = '0;
                            if (i_last)
                            begin
                                state_next = ST_DRAIN;
                            end
                            else
                            begin
                                i_next = i_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                // wait until the last write-back has left the pipeline
                if (pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            t_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            t_reg     <= t_next;
        end
    end

    // A and B stores
    always_ff @(posedge clk)
    begin
        if (ld_a)
        begin
            store_a[ld_addr] <= q_item.value;
        end
        if (adv)
        begin
            a_rd_reg <= store_a[a_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_b)
        begin
            store_b[ld_addr] <= q_item.value;
        end
        if (adv)
        begin
            b_rd_reg <= store_b[b_addr];
        end
    end

    // Round the exact sum to nearest, add the old C value, saturate.
    assign rnd    = acc_reg[ACC_W-1:FRAC_W];
    assign total  = TOT_W'(rnd) + TOT_W'(s3_c_reg);
    assign finish = adv && s3_tag_reg.valid && s3_tag_reg.last;

    always_comb
    begin
        priority if (total > TOT_W'(VAL_MAX))
        begin
            sat_value = VAL_MAX;
        end
        else if (total < TOT_W'(VAL_MIN))
        begin
            sat_value = VAL_MIN;
        end
        else
        begin
            sat_value = total[VAL_W-1:0];
        end
    end

    // C store: loads and write-backs never overlap, a run is drained first.
    always_ff @(posedge clk)
    begin
        priority if (ld_c)
        begin
            store_c[ld_addr] <= q_item.value;
        end
        else if (finish)
        begin
            store_c[s3_tag_reg.ci] <= sat_value;
        end
        if (adv)
        begin
            c_rd_reg  <= store_c[c_addr];
            c_hit_reg <= c_valid_reg[c_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= '0;
        end
        else
        begin
            if (ld_c)
            begin
                c_valid_reg[ld_addr] <= 1'b1;
            end
            else if (finish)
            begin
                c_valid_reg[s3_tag_reg.ci] <= 1'b1;
            end
        end
    end

    // Tags travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else if (adv)
        begin
            s1_tag_reg <= issue_tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= a_rd_reg * b_rd_reg;
            s2_c_reg <= c_hit_reg ? c_rd_reg : '0;
            s3_c_reg <= s2_c_reg;
            if (s2_tag_reg.valid)
            begin
                // seed with half an LSB so the shift into rnd rounds
                acc_reg <= (s2_tag_reg.first ? RND_BIAS : acc_reg) + ACC_W'(prod_reg);
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_tag_reg.valid && s3_tag_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_value_reg <= sat_value;
            out_index_reg <= IDX_W'(s3_tag_reg.ci);
            out_last_reg  <= s3_tag_reg.run_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_value = out_value_reg;
    assign result_index = out_index_reg;
    assign is_last      = out_last_reg;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for matrix_multiply_accumulate_core. A queue of
// commands feeds a clocked driver; a clocked monitor predicts every C update
// in Q16.16 with exact wide sums and compares each result transfer against
// it. Phases change dimensions, pacing and back-pressure.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mma_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int DEPTH          = DEFAULT_MAX_DIM * DEFAULT_MAX_DIM;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic [1:0] {
        PACE_LIGHT_SEND,   // sender idles 24%, receiver 49%
        PACE_HEAVY_SEND,   // sender idles 49%, receiver 24%
        PACE_NONE
    } pace_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        index;
        logic                    last;
    } c_elem_t;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index    = '0;
    logic [DIM_W-1:0]        cfg_data     = '0;
    logic                    cmd_valid    = 1'b0;
    logic                    cmd_stall;
    logic [1:0]              command      = '0;
    logic [IDX_W-1:0]        elem_index   = '0;
    logic signed [VAL_W-1:0] elem_value   = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic signed [VAL_W-1:0] result_value;
    logic [IDX_W-1:0]        result_index;
    logic                    is_last;

    matrix_multiply_accumulate_core dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predicted core state
    logic [DIM_W-1:0]        reg_m = RESET_DIM;
    logic [DIM_W-1:0]        reg_n = RESET_DIM;
    logic [DIM_W-1:0]        reg_k = RESET_DIM;
    logic signed [VAL_W-1:0] mat_a [DEPTH] = '{default: '0};
    logic signed [VAL_W-1:0] mat_b [DEPTH] = '{default: '0};
    logic signed [VAL_W-1:0] mat_c [DEPTH] = '{default: '0};
    c_elem_t                 c_updates [$];

    // Stimulus side
    mma_item_t cmd_backlog [$];
    int        gen_m = DEFAULT_MAX_DIM;
    int        gen_n = DEFAULT_MAX_DIM;
    int        gen_k = DEFAULT_MAX_DIM;
    bit        a_set [DEPTH] = '{default: 1'b0};
    bit        b_set [DEPTH] = '{default: 1'b0};
    pace_t     pace = PACE_LIGHT_SEND;
    logic      cmd_taken = 1'b0;
    logic      hold_armed = 1'b0;
    logic      hold_done = 1'b0;
    int        hold_left = 0;

    int idle_cycles = 0;
    int n_errors = 0;
    int n_results = 0;
    int n_runs = 0;
    int n_loads = 0;
    int n_stray = 0;
    int n_settings = 0;
    int n_held_off = 0;

    function automatic int clamp_dim(input logic [DIM_W-1:0] r);
        if (r == '0)
        begin
            return 1;
        end
        if (int'(r) > DEFAULT_MAX_DIM)
        begin
            return DEFAULT_MAX_DIM;
        end
        return int'(r);
    endfunction

    task automatic mac_command(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                               input logic signed [VAL_W-1:0] val);
        int m, n, k;
        logic signed [71:0] acc, pa, pb, total, hi_lim, lo_lim;
        c_elem_t elem;
        m = clamp_dim(reg_m);
        n = clamp_dim(reg_n);
        k = clamp_dim(reg_k);
        hi_lim = VAL_MAX;
        lo_lim = VAL_MIN;
        if (cmd != CMD_RUN)
        begin
            n_loads++;
        end
        case (cmd)
            CMD_LOAD_A:
                if (int'(idx) < m * k) mat_a[idx] = val;
                else n_stray++;
            CMD_LOAD_B:
                if (int'(idx) < k * n) mat_b[idx] = val;
                else n_stray++;
            CMD_LOAD_C:
                if (int'(idx) < m * n) mat_c[idx] = val;
                else n_stray++;
            CMD_RUN:
            begin
                n_runs++;
                for (int i = 0; i < m; i++)
                begin
                    for (int j = 0; j < n; j++)
                    begin
                        acc = '0;
                        for (int t = 0; t < k; t++)
                        begin
                            pa = mat_a[i * k + t];
                            pb = mat_b[t * n + j];
                            acc = acc + pa * pb;
                        end
                        // round the exact Q32.32 sum to nearest, ties up
                        pa = mat_c[i * n + j];
                        total = ((acc + 72'sd32768) >>> 16) + pa;
                        if (total > hi_lim) total = hi_lim;
                        else if (total < lo_lim) total = lo_lim;
                        elem.value = total[VAL_W-1:0];
                        elem.index = IDX_W'(i * n + j);
                        elem.last  = (i == m - 1) && (j == n - 1);
                        mat_c[i * n + j] = elem.value;
                        c_updates.push_back(elem);
                    end
                end
            end
        endcase
    endtask

    function automatic logic sender_idles();
        case (pace)
            PACE_LIGHT_SEND: return $urandom_range(0, 99) < 24;
            PACE_HEAVY_SEND: return $urandom_range(0, 99) < 49;
            default:         return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_idles();
        case (pace)
            PACE_LIGHT_SEND: return $urandom_range(0, 99) < 49;
            PACE_HEAVY_SEND: return $urandom_range(0, 99) < 24;
            default:         return 1'b0;
        endcase
    endfunction

    // Driver: hold a stalled transfer, otherwise take the next pending command
    always @(negedge clk)
    begin
        mma_item_t it;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (!cmd_valid || cmd_taken)
        begin
            if (cmd_backlog.size() != 0 && !sender_idles())
            begin
                it = cmd_backlog.pop_front();
                cmd_valid  <= 1'b1;
                command    <= it.cmd;
                elem_index <= it.idx;
                elem_value <= it.value;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (hold_armed && !hold_done && result_valid)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= receiver_idles();
        end
    end

    // Monitor: register writes, command transfers, result checks, watchdog
    always @(posedge clk)
    begin
        c_elem_t want;
        logic moved;
        moved = 1'b0;
        cmd_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_ROWS_M:  reg_m = cfg_data;
                    REG_COLS_N:  reg_n = cfg_data;
                    REG_INNER_K: reg_k = cfg_data;
                    default: ;
                endcase
            end
            if (cmd_valid && !cmd_stall)
            begin
                cmd_taken = 1'b1;
                moved = 1'b1;
                mac_command(cmd_t'(command), elem_index, elem_value);
            end
            else if (cmd_valid)
            begin
                n_held_off++;
            end
            if (result_valid && !result_stall)
            begin
                moved = 1'b1;
                if (c_updates.size() == 0)
                begin
                    $display("%0t: result with nothing expected: index %0d value %0d",
                             $time, result_index, result_value);
                    n_errors++;
                end
                else
                begin
                    want = c_updates.pop_front();
                    n_results++;
                    if (result_value !== want.value)
                    begin
                        $display("%0t: result_value expected %0d got %0d",
                                 $time, want.value, result_value);
                        n_errors++;
                    end
                    if (result_index !== want.index)
                    begin
                        $display("%0t: result_index expected %0d got %0d",
                                 $time, want.index, result_index);
                        n_errors++;
                    end
                    if (is_last !== want.last)
                    begin
                        $display("%0t: is_last expected %0d got %0d",
                                 $time, want.last, is_last);
                        n_errors++;
                    end
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("matrix_multiply_accumulate_core test failed");
            $finish;
        end
    end

    function automatic logic signed [VAL_W-1:0] rand_elem();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = VAL_MAX;
            1: v = VAL_MIN;
            2: v = '0;
            3, 4, 5:
            begin
                // within +-2.0
                v = $urandom_range(0, 262143);
                v = v - 131072;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int store_limit(input cmd_t cmd);
        case (cmd)
            CMD_LOAD_A: return gen_m * gen_k;
            CMD_LOAD_B: return gen_k * gen_n;
            CMD_LOAD_C: return gen_m * gen_n;
            default:    return 0;
        endcase
    endfunction

    task automatic push_item(input cmd_t cmd, input int idx,
                             input logic signed [VAL_W-1:0] val);
        mma_item_t it;
        it.cmd   = cmd;
        it.idx   = IDX_W'(idx);
        it.value = val;
        if (idx < store_limit(cmd))
        begin
            if (cmd == CMD_LOAD_A) a_set[idx] = 1'b1;
            else if (cmd == CMD_LOAD_B) b_set[idx] = 1'b1;
        end
        cmd_backlog.push_back(it);
    endtask

    // Fill any A or B entry the run would read that was never written
    task automatic push_run();
        for (int t = 0; t < gen_m * gen_k; t++)
        begin
            if (!a_set[t]) push_item(CMD_LOAD_A, t, rand_elem());
        end
        for (int t = 0; t < gen_k * gen_n; t++)
        begin
            if (!b_set[t]) push_item(CMD_LOAD_B, t, rand_elem());
        end
        push_item(CMD_RUN, $urandom_range(0, 63), $urandom);
    endtask

    task automatic run_phase(input int target);
        int count;
        int pick;
        int lim;
        cmd_t cmd;
        count = 0;
        while (count < target)
        begin
            pick = $urandom_range(0, 99);
            cmd = cmd_t'($urandom_range(0, 2));
            lim = store_limit(cmd);
            if (pick < 12)
            begin
                push_run();
                count++;
            end
            else if (pick < 22 && lim < DEPTH)
            begin
                push_item(cmd, $urandom_range(lim, DEPTH - 1), rand_elem());
            end
            else
            begin
                push_item(cmd, $urandom_range(0, lim - 1), rand_elem());
                count++;
            end
        end
        push_run();
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] n,
                            input logic [DIM_W-1:0] k);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_ROWS_M;
        cfg_data     <= m;
        @(negedge clk);
        cfg_index <= REG_COLS_N;
        cfg_data  <= n;
        @(negedge clk);
        cfg_index <= REG_INNER_K;
        cfg_data  <= k;
        @(negedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= DIM_W'($urandom_range(0, 15));
        @(negedge clk);
        cfg_write_en <= 1'b0;
        gen_m = clamp_dim(m);
        gen_n = clamp_dim(n);
        gen_k = clamp_dim(k);
        n_settings++;
    endtask

    // Wait for every queued command and every result, then let the core drain
    task automatic settle();
        while (cmd_backlog.size() != 0 || cmd_valid || c_updates.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Zero registers act as 1x1x1
        set_dims(4'd0, 4'd0, 4'd0);
        push_item(CMD_LOAD_A, 0, VAL_MAX);
        push_item(CMD_LOAD_B, 0, VAL_MAX);
        push_item(CMD_LOAD_C, 0, '0);
        push_run();                              // saturate high
        push_item(CMD_LOAD_A, 63, '0);           // outside the matrix: drop
        push_item(CMD_LOAD_B, 1, 32'sh5A5A_A5A5);
        push_item(CMD_LOAD_C, 1, VAL_MIN);
        push_item(CMD_LOAD_A, 0, VAL_MIN);
        push_run();                              // saturate low
        push_item(CMD_LOAD_A, 0, 32'sd1);
        push_item(CMD_LOAD_B, 0, 32'sd32768);
        push_item(CMD_LOAD_C, 0, '0);
        push_run();                              // half LSB rounds up
        push_item(CMD_LOAD_A, 0, -32'sd1);
        push_item(CMD_LOAD_C, 0, '0);
        push_run();                              // minus half LSB rounds to zero
        push_item(CMD_LOAD_A, 0, VAL_MIN);
        push_item(CMD_LOAD_B, 0, VAL_MIN);
        push_run();
        push_item(CMD_LOAD_C, 0, VAL_MIN);
        push_item(CMD_LOAD_A, 0, '0);
        push_run();
        settle();

        // Long receiver hold-off on the first run fills the command queue
        set_dims(4'd2, 4'd3, 4'd4);
        hold_armed <= 1'b1;
        push_run();
        run_phase(15);
        settle();

        pace <= PACE_HEAVY_SEND;
        set_dims(4'd1, 4'd8, 4'd8);
        run_phase(15);
        settle();

        // Above the maximum acts as the maximum
        set_dims(4'd15, 4'd12, 4'd9);
        run_phase(10);
        settle();

        pace <= PACE_NONE;
        set_dims(DIM_W'($urandom_range(0, 15)), DIM_W'($urandom_range(0, 15)),
                 DIM_W'($urandom_range(0, 15)));
        run_phase(15);
        settle();

        set_dims(4'd5, 4'd1, 4'd8);
        run_phase(10);
        settle();

        $display("Covered %0d runs and %0d checked C elements over %0d dimension settings.",
                 n_runs, n_results, n_settings);
        $display("Loads: %0d (%0d outside the matrix); input held off for %0d cycles.",
                 n_loads, n_stray, n_held_off);
        if (n_errors == 0 && c_updates.size() == 0)
        begin
            $display("matrix_multiply_accumulate_core test passed");
        end
        else
        begin
            $display("matrix_multiply_accumulate_core test failed");
        end
        $finish;
    end

endmodule

@@ matrix_multiply_accumulate_core.f @@
sv/mma_pkg.sv
sv/mma_front.sv
sv/mma_queue.sv
sv/mma_back.sv
sv/matrix_multiply_accumulate_core.sv
bench/testbench.sv
